@@ design/assert_macros.svh @@
// Assertion macros for the checker file of the particle block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property under the block clock, off while reset is asserted
`define PLU_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error(msg);

// A valid that is not taken must still be up on the next edge
`define PLU_ASSERT_HOLD(lbl, ck, rn, vld, rdy, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (vld) && !(rdy) |=> (vld)) \
		else $error(msg);

`endif

@@ design/plu_pkg.sv @@
// Package for the particle lifetime update block: sizes, codes, entry layout
// and the fixed-point helpers. No dependencies.
`default_nettype none

package plu_pkg;

	localparam int NUM_PARTICLES = 64;
	localparam int IDX_W = 6;
	localparam int ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int Q_W = 20;
	localparam int VEC_W = 3 * Q_W;
	localparam int DT_W = 19;
	localparam int PROD_W = 2 * Q_W;
	localparam int FRAC_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int STAG_W = 12;
	localparam int REM_W = 4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTICLES - 1);
	localparam logic [DT_W-1:0] BASE_LIFE_RST = DT_W'(1024);
	localparam logic signed [Q_W-1:0] Q_MAX = 20'sh7FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 20'sh80000;
	localparam logic [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << FRAC_W) - 1);

	// Command codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_INIT = 1'b1;

	// Index-pattern counters: i mod 5 and i mod 3 wrap points
	localparam logic [2:0] A_LAST = 3'd4;
	localparam logic [1:0] C_LAST = 2'd2;

	// 0.05 per index in Q10.10 is 512/10 = 51 rem 2 per step
	localparam logic [STAG_W-1:0] STAG_Q_STEP = 12'd51;
	localparam logic [REM_W-1:0] STAG_R_STEP = 4'd2;
	localparam logic [REM_W-1:0] STAG_DIV = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN,
		CFG_SPREAD,
		CFG_BASE_VEL,
		CFG_BASE_LIFE
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// x lowest, z highest, matching the packed register layout
	typedef struct packed {
		logic signed [Q_W-1:0] z;
		logic signed [Q_W-1:0] y;
		logic signed [Q_W-1:0] x;
	} vec_t;

	// One particle as held in the table memory
	typedef struct packed {
		vec_t                  pos;
		vec_t                  vel;
		logic signed [Q_W-1:0] life;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One particle slot handed from the sequencer to the update pipeline
	typedef struct packed {
		logic              valid;
		logic              init;
		logic [DT_W-1:0]   dt;
		logic [IDX_W-1:0]  idx;
		logic [2:0]        a;
		logic [1:0]        c;
		logic [STAG_W-1:0] stag;
		logic              last;
	} issue_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [31:0] v);
		logic signed [Q_W-1:0] r;
		if (v > 32'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < 32'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	// 0.1 * (i mod 5), truncated to Q10.10
	function automatic logic [8:0] life_bonus(input logic [2:0] a);
		logic [8:0] r;
		case (a)
			3'd0: r = 9'd0;
			3'd1: r = 9'd102;
			3'd2: r = 9'd204;
			3'd3: r = 9'd307;
			3'd4: r = 9'd409;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// 0.05 * (i mod 4), truncated to Q10.10
	function automatic logic [7:0] vel_bonus(input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0: r = 8'd0;
			2'd1: r = 8'd51;
			2'd2: r = 8'd102;
			default: r = 8'd153;
		endcase
		return r;
	endfunction

	// pos + vel*dt/1024, quotient truncated toward zero, then clamped
	function automatic logic signed [Q_W-1:0] move_axis(input logic signed [Q_W-1:0] p,
			input logic signed [PROD_W-1:0] m);
		logic signed [PROD_W-1:0] adj;
		logic signed [PROD_W-1:0] d;
		adj = m[PROD_W-1] ? (m + ROUND_ADJ) : m;
		d = adj >>> FRAC_W;
		return sat_q(32'(p) + 32'(d));
	endfunction

endpackage

`default_nettype wire

@@ design/plu_if.sv @@
// Handshake channels of the particle block: command in, position word out.
// Depends on plu_pkg for field widths.
`default_nettype none

interface plu_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [plu_pkg::DT_W-1:0]    step_dt;

	modport source (output valid, func, step_dt, input ready);
	modport sink (input valid, func, step_dt, output ready);
endinterface

interface plu_out_if;
	logic                          valid;
	logic                          ready;
	logic [plu_pkg::IDX_W-1:0]     particle_index;
	logic signed [plu_pkg::Q_W-1:0] pos_x;
	logic signed [plu_pkg::Q_W-1:0] pos_y;
	logic signed [plu_pkg::Q_W-1:0] pos_z;
	logic                          respawned;
	logic                          last;

	modport source (output valid, particle_index, pos_x, pos_y, pos_z, respawned, last,
		input ready);
	modport sink (input valid, particle_index, pos_x, pos_y, pos_z, respawned, last,
		output ready);
endinterface

`default_nettype wire

@@ design/plu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/plu_seq.sv @@
// Command sequencer: takes a command word and walks the particle indexes,
// keeping the index-pattern counters. Depends on plu_pkg and plu_if.
`default_nettype none

module plu_seq (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     pipe_busy,
	plu_in_if.sink        cmd,
	output plu_pkg::issue_t iss
);

	plu_pkg::state_t state_q;
	plu_pkg::state_t state_d;

	logic [plu_pkg::IDX_W-1:0]  idx_q;
	logic [2:0]                 a_q;
	logic [1:0]                 c_q;
	logic [plu_pkg::STAG_W-1:0] stag_q;
	logic [plu_pkg::REM_W-1:0]  rem_q;
	logic [plu_pkg::REM_W-1:0]  rem_sum;
	logic                       init_q;
	logic [plu_pkg::DT_W-1:0]   dt_q;
	logic                       accept;
	logic                       step;
	logic                       at_last;

	assign accept  = cmd.valid && cmd.ready;
	assign step    = (state_q == plu_pkg::ST_RUN) && adv;
	assign at_last = (idx_q == plu_pkg::LAST_IDX);
	assign rem_sum = rem_q + plu_pkg::STAG_R_STEP;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plu_pkg::ST_IDLE: begin
				if (accept) state_d = plu_pkg::ST_RUN;
			end
			plu_pkg::ST_RUN: begin
				if (step && at_last) state_d = plu_pkg::ST_IDLE;
			end
			default: state_d = plu_pkg::ST_IDLE;
		endcase
	end

	// Outputs: take a command only once stages 1 and 2 of the pipeline are empty
	always_comb begin
		cmd.ready  = 1'b0;
		iss.valid  = 1'b0;
		case (state_q)
			plu_pkg::ST_IDLE: cmd.ready = !pipe_busy;
			plu_pkg::ST_RUN:  iss.valid = 1'b1;
			default: begin
				cmd.ready = 1'b0;
				iss.valid = 1'b0;
			end
		endcase
		iss.init = init_q;
		iss.dt   = dt_q;
		iss.idx  = idx_q;
		iss.a    = a_q;
		iss.c    = c_q;
		iss.stag = stag_q;
		iss.last = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance index and pattern counters, restart on a new command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			a_q    <= '0;
			c_q    <= '0;
			stag_q <= '0;
			rem_q  <= '0;
		end else if (accept) begin
			idx_q  <= '0;
			a_q    <= '0;
			c_q    <= '0;
			stag_q <= '0;
			rem_q  <= '0;
		end else if (step) begin
			idx_q <= idx_q + 1'b1;
			a_q   <= (a_q == plu_pkg::A_LAST) ? 3'd0 : (a_q + 3'd1);
			c_q   <= (c_q == plu_pkg::C_LAST) ? 2'd0 : (c_q + 2'd1);
			if (rem_sum >= plu_pkg::STAG_DIV) begin
				rem_q  <= rem_sum - plu_pkg::STAG_DIV;
				stag_q <= stag_q + plu_pkg::STAG_Q_STEP + 1'b1;
			end else begin
				rem_q  <= rem_sum;
				stag_q <= stag_q + plu_pkg::STAG_Q_STEP;
			end
		end
	end

	// Hold the command word for the whole run
	always_ff @(posedge clk) begin
		if (accept) begin
			init_q <= (cmd.func == plu_pkg::FUNC_INIT);
			dt_q   <= cmd.step_dt;
		end
	end

endmodule

`default_nettype wire

@@ design/plu_upd.sv @@
// Update pipeline: lifetime decrement, respawn, Euler move, write-back and
// the output register. Depends on plu_pkg and plu_if.
`default_nettype none

module plu_upd (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire plu_pkg::issue_t               iss,
	input  wire plu_pkg::entry_t               rd_data,
	input  wire logic [plu_pkg::VEC_W-1:0]     origin,
	input  wire logic [plu_pkg::VEC_W-1:0]     spread,
	input  wire logic [plu_pkg::VEC_W-1:0]     base_vel,
	input  wire logic [plu_pkg::DT_W-1:0]      base_life,
	output logic                               adv,
	output logic                               busy,
	output logic                               wr_en,
	output logic [plu_pkg::ADDR_W-1:0]         wr_addr,
	output plu_pkg::entry_t                    wr_data,
	plu_out_if.source                          res
);

	// Stage 1: slot info lines up with the read data from the table
	plu_pkg::issue_t iss_s1;

	plu_pkg::vec_t  org;
	plu_pkg::vec_t  spr;
	plu_pkg::vec_t  bvel;
	plu_pkg::entry_t rsp;
	plu_pkg::entry_t base_ent;
	logic signed [plu_pkg::Q_W:0]   sx_w;
	logic signed [plu_pkg::Q_W:0]   sz_w;
	logic signed [plu_pkg::Q_W:0]   half_sum;
	logic signed [plu_pkg::Q_W:0]   half_x;
	logic signed [plu_pkg::Q_W:0]   offx;
	logic signed [plu_pkg::Q_W:0]   offz;
	logic signed [plu_pkg::Q_W-1:0] life_base;
	logic signed [plu_pkg::Q_W-1:0] life_init;
	logic signed [plu_pkg::Q_W-1:0] life_dec;
	logic signed [plu_pkg::DT_W:0]  dt_s;
	logic signed [plu_pkg::PROD_W-1:0] prod_x;
	logic signed [plu_pkg::PROD_W-1:0] prod_y;
	logic signed [plu_pkg::PROD_W-1:0] prod_z;
	logic                           resp;

	// Stage 2
	logic                              v_s2;
	plu_pkg::entry_t                   ent_s2;
	logic signed [plu_pkg::PROD_W-1:0] prod_x_s2;
	logic signed [plu_pkg::PROD_W-1:0] prod_y_s2;
	logic signed [plu_pkg::PROD_W-1:0] prod_z_s2;
	logic                              resp_s2;
	logic [plu_pkg::IDX_W-1:0]         idx_s2;
	logic                              last_s2;
	plu_pkg::entry_t                   fin;

	// Output register
	logic                      out_valid_q;
	logic [plu_pkg::IDX_W-1:0] out_idx_q;
	plu_pkg::vec_t             out_pos_q;
	logic                      out_resp_q;
	logic                      out_last_q;

	assign adv  = !out_valid_q || res.ready;
	assign busy = iss_s1.valid || v_s2;

	assign org  = plu_pkg::vec_t'(origin);
	assign spr  = plu_pkg::vec_t'(spread);
	assign bvel = plu_pkg::vec_t'(base_vel);

	// Respawn values from the emitter registers and the index pattern
	always_comb begin
		sx_w     = {spr.x[plu_pkg::Q_W-1], spr.x};
		sz_w     = {spr.z[plu_pkg::Q_W-1], spr.z};
		half_sum = sx_w + (plu_pkg::Q_W + 1)'(spr.x[plu_pkg::Q_W-1]);
		half_x   = half_sum >>> 1;
		case (iss_s1.a)
			3'd0: offx = -sx_w;
			3'd1: offx = -half_x;
			3'd2: offx = '0;
			3'd3: offx = half_x;
			default: offx = sx_w;
		endcase
		case (iss_s1.c)
			2'd0: offz = -sz_w;
			2'd1: offz = '0;
			default: offz = sz_w;
		endcase

		life_base = plu_pkg::sat_q($signed(32'(base_life))
			+ $signed(32'(plu_pkg::life_bonus(iss_s1.a))));
		life_init = plu_pkg::sat_q(32'(life_base) - $signed(32'(iss_s1.stag)));

		rsp.pos.x = plu_pkg::sat_q(32'(org.x) + 32'(offx));
		rsp.pos.y = plu_pkg::sat_q(32'(org.y) + 32'(spr.y));
		rsp.pos.z = plu_pkg::sat_q(32'(org.z) + 32'(offz));
		rsp.vel.x = bvel.x;
		rsp.vel.y = plu_pkg::sat_q(32'(bvel.y)
			+ $signed(32'(plu_pkg::vel_bonus(iss_s1.idx[1:0]))));
		rsp.vel.z = bvel.z;
		rsp.life  = iss_s1.init ? life_init : life_base;
	end

	// Lifetime step, respawn decision and the velocity products
	always_comb begin
		dt_s     = $signed({1'b0, iss_s1.dt});
		life_dec = plu_pkg::sat_q(32'(rd_data.life) - 32'(dt_s));
		resp     = iss_s1.init || life_dec[plu_pkg::Q_W-1] || (life_dec == '0);
		base_ent = rd_data;
		base_ent.life = life_dec;
		if (resp) base_ent = rsp;
		prod_x = rd_data.vel.x * dt_s;
		prod_y = rd_data.vel.y * dt_s;
		prod_z = rd_data.vel.z * dt_s;
	end

	// Move surviving particles
	always_comb begin
		fin = ent_s2;
		if (!resp_s2) begin
			fin.pos.x = plu_pkg::move_axis(ent_s2.pos.x, prod_x_s2);
			fin.pos.y = plu_pkg::move_axis(ent_s2.pos.y, prod_y_s2);
			fin.pos.z = plu_pkg::move_axis(ent_s2.pos.z, prod_z_s2);
		end
	end

	// Write back as the word moves to the output register
	assign wr_en   = v_s2 && adv;
	assign wr_addr = idx_s2[plu_pkg::ADDR_W-1:0];
	assign wr_data = fin;

	// Advance stage valids, hold on a stalled output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1      <= '0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			iss_s1      <= iss;
			v_s2        <= iss_s1.valid;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s2    <= base_ent;
			prod_x_s2 <= prod_x;
			prod_y_s2 <= prod_y;
			prod_z_s2 <= prod_z;
			resp_s2   <= resp;
			idx_s2    <= iss_s1.idx;
			last_s2   <= iss_s1.last;
			if (v_s2) begin
				out_idx_q  <= idx_s2;
				out_pos_q  <= fin.pos;
				out_resp_q <= resp_s2;
				out_last_q <= last_s2;
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.particle_index = out_idx_q;
	assign res.pos_x          = out_pos_q.x;
	assign res.pos_y          = out_pos_q.y;
	assign res.pos_z          = out_pos_q.z;
	assign res.respawned      = out_resp_q;
	assign res.last           = out_last_q;

endmodule

`default_nettype wire

@@ design/particle_lifetime_update.sv @@
// Top level of the particle lifetime update block: configuration registers,
// particle table RAM, sequencer and update pipeline.
// Depends on plu_pkg, plu_if, plu_ram, plu_seq and plu_upd.
//
//   channel  dir  word                                           handshake
//   cmd      in   func, step_dt                                  valid/ready
//   res      out  particle_index, pos_x/y/z, respawned, last     valid/ready
//   cfg      in   cfg_index, cfg_data                            cfg_we, no wait
//
// A command produces NUM_PARTICLES result words, one per cycle while res is
// not stalled; the table RAM is read and written once per particle, and the
// next command is taken only once pipeline stages 1 and 2 are empty.
// A stall on res freezes the whole pipeline, RAM read data included.
// Reset clears control and the configuration registers only; the table holds
// garbage until an initialize command has run, and there is no clearing pass.
`default_nettype none

module particle_lifetime_update (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [plu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plu_pkg::VEC_W-1:0]        cfg_data,
	plu_in_if.sink                                cmd,
	plu_out_if.source                             res
);

	logic [plu_pkg::VEC_W-1:0] origin_q;
	logic [plu_pkg::VEC_W-1:0] spread_q;
	logic [plu_pkg::VEC_W-1:0] base_vel_q;
	logic [plu_pkg::DT_W-1:0]  base_life_q;

	plu_pkg::issue_t           iss;
	plu_pkg::entry_t           rd_data;
	logic [plu_pkg::ENTRY_W-1:0] rd_raw;
	logic                      adv;
	logic                      busy;
	logic                      wr_en;
	logic [plu_pkg::ADDR_W-1:0] wr_addr;
	plu_pkg::entry_t           wr_data;
	logic                      rd_en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q    <= '0;
			spread_q    <= '0;
			base_vel_q  <= '0;
			base_life_q <= plu_pkg::BASE_LIFE_RST;
		end else if (cfg_we) begin
			case (plu_pkg::cfg_idx_t'(cfg_index))
				plu_pkg::CFG_ORIGIN:    origin_q    <= cfg_data;
				plu_pkg::CFG_SPREAD:    spread_q    <= cfg_data;
				plu_pkg::CFG_BASE_VEL:  base_vel_q  <= cfg_data;
				plu_pkg::CFG_BASE_LIFE: base_life_q <= cfg_data[plu_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	plu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pipe_busy (busy),
		.cmd       (cmd),
		.iss       (iss)
	);

	// Read the slot being issued; stage 1 picks the data up in the next cycle
	assign rd_en   = iss.valid && adv;
	assign rd_data = plu_pkg::entry_t'(rd_raw);

	plu_ram #(
		.WIDTH (plu_pkg::ENTRY_W),
		.DEPTH (plu_pkg::NUM_PARTICLES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (iss.idx[plu_pkg::ADDR_W-1:0]),
		.rdata (rd_raw)
	);

	plu_upd u_upd (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss       (iss),
		.rd_data   (rd_data),
		.origin    (origin_q),
		.spread    (spread_q),
		.base_vel  (base_vel_q),
		.base_life (base_life_q),
		.adv       (adv),
		.busy      (busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res       (res)
	);

endmodule

`default_nettype wire

@@ design/plu_chk.sv @@
// Port-level checker for the particle block, bound to the top level.
// Depends on plu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module plu_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cmd_valid,
	input wire logic                      cmd_ready,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [plu_pkg::IDX_W-1:0] res_index,
	input wire logic                      res_last
);

	logic [plu_pkg::IDX_W-1:0] exp_idx_q;
	logic                      seen_q;

	// Track the index the next delivered word must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				exp_idx_q <= res_last ? '0 : (exp_idx_q + 1'b1);
			end
			if (cmd_valid && cmd_ready) begin
				seen_q <= 1'b1;
			end
		end
	end

	`PLU_ASSERT_HOLD(a_res_hold, clk, arst_n, res_valid, res_ready, "result word dropped")
	`PLU_ASSERT(a_res_order, clk, arst_n, res_valid && res_ready |-> res_index == exp_idx_q, "index out of order")
	`PLU_ASSERT(a_res_last, clk, arst_n, res_valid |-> res_last == (res_index == plu_pkg::LAST_IDX), "last flag wrong")
	`PLU_ASSERT(a_res_cause, clk, arst_n, res_valid |-> seen_q, "result without a command")

endmodule

bind particle_lifetime_update plu_chk u_plu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_index (res.particle_index),
	.res_last  (res.last)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for particle_lifetime_update: drives init and tick commands,
// tracks the particle table in a scoreboard class and checks every position word.
// Depends on plu_pkg, plu_if and the particle_lifetime_update RTL.

module tb_top;
	import plu_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 600;
	localparam int LONG_HOLD_AT = 6000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 75;
	localparam int QUIET_FROM = 400;
	localparam int TAIL_CYCLES = NUM_PARTICLES + 16;

	// One position word as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
		logic signed [Q_W-1:0] z;
		logic                  respawned;
		logic                  last;
	} pos_word_t;

	class particle_scoreboard;
		logic [VEC_W-1:0] origin;
		logic [VEC_W-1:0] spread;
		logic [VEC_W-1:0] base_vel;
		logic [DT_W-1:0]  base_life;
		int pos[NUM_PARTICLES][3];
		int vel[NUM_PARTICLES][3];
		int life[NUM_PARTICLES];
		pos_word_t expected_positions[$];
		int mismatches;

		function new();
			origin = '0;
			spread = '0;
			base_vel = '0;
			base_life = BASE_LIFE_RST;
			mismatches = 0;
		endfunction

		function int clamp_q(longint v);
			if (v > 524287) return 524287;
			if (v < -524288) return -524288;
			return int'(v);
		endfunction

		function longint lane(logic [VEC_W-1:0] vec, int ax);
			logic signed [Q_W-1:0] f;
			f = vec[ax*Q_W +: Q_W];
			return longint'(f);
		endfunction

		function void set_reg(cfg_idx_t idx, logic [VEC_W-1:0] data);
			case (idx)
				CFG_ORIGIN: origin = data;
				CFG_SPREAD: spread = data;
				CFG_BASE_VEL: base_vel = data;
				CFG_BASE_LIFE: base_life = data[DT_W-1:0];
				default: ;
			endcase
		endfunction

		// Place a particle around the emitter with its index-patterned offsets
		function void respawn_particle(int i);
			longint a;
			longint c;
			longint k;
			a = i % 5;
			c = i % 3;
			k = i % 4;
			pos[i][0] = clamp_q(lane(origin, 0) + (lane(spread, 0) * (a - 2)) / 2);
			pos[i][1] = clamp_q(lane(origin, 1) + lane(spread, 1));
			pos[i][2] = clamp_q(lane(origin, 2) + lane(spread, 2) * (c - 1));
			vel[i][0] = int'(lane(base_vel, 0));
			vel[i][1] = clamp_q(lane(base_vel, 1) + (k * 512) / 10);
			vel[i][2] = int'(lane(base_vel, 2));
			life[i] = clamp_q(longint'(base_life) + (a * 1024) / 10);
		endfunction

		// Advance the table by one command and queue the words it must emit
		function void note_command(logic f, logic [DT_W-1:0] dt);
			pos_word_t w;
			logic resp;
			for (int i = 0; i < NUM_PARTICLES; i++) begin
				resp = 1'b0;
				if (f == FUNC_INIT) begin
					respawn_particle(i);
					life[i] = clamp_q(longint'(life[i]) - (longint'(i) * 512) / 10);
					resp = 1'b1;
				end else begin
					life[i] = clamp_q(longint'(life[i]) - longint'(dt));
					if (life[i] <= 0) begin
						respawn_particle(i);
						resp = 1'b1;
					end else begin
						for (int ax = 0; ax < 3; ax++) begin
							pos[i][ax] = clamp_q(longint'(pos[i][ax])
								+ (longint'(vel[i][ax]) * longint'(dt)) / 1024);
						end
					end
				end
				w.idx = IDX_W'(i);
				w.x = Q_W'(pos[i][0]);
				w.y = Q_W'(pos[i][1]);
				w.z = Q_W'(pos[i][2]);
				w.respawned = resp;
				w.last = (i == NUM_PARTICLES - 1);
				expected_positions.insert(expected_positions.size(), w);
			end
		endfunction

		// Compare one received word with the oldest expected one
		function void check_position(pos_word_t got);
			pos_word_t exp_w;
			if (expected_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: idx=%0d x=%0d y=%0d z=%0d resp=%0b last=%0b",
						got.idx, got.x, got.y, got.z, got.respawned, got.last);
				return;
			end
			exp_w = expected_positions.pop_front();
			if (got.idx != exp_w.idx || got.x != exp_w.x || got.y != exp_w.y
					|| got.z != exp_w.z || got.respawned != exp_w.respawned
					|| got.last != exp_w.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: idx=%0d x=%0d y=%0d z=%0d resp=%0b last=%0b",
						exp_w.idx, exp_w.x, exp_w.y, exp_w.z, exp_w.respawned, exp_w.last);
					$display("         got: idx=%0d x=%0d y=%0d z=%0d resp=%0b last=%0b",
						got.idx, got.x, got.y, got.z, got.respawned, got.last);
				end
			end
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VEC_W-1:0] cfg_data;

	plu_in_if cmd_ch();
	plu_out_if res_ch();

	particle_scoreboard table_sb = new();

	bit idle_en = 1'b1;
	bit quiet = 1'b0;
	int words_seen = 0;

	particle_lifetime_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always #5 clk = ~clk;

	function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
		return {z[Q_W-1:0], y[Q_W-1:0], x[Q_W-1:0]};
	endfunction

	// Mix of extremes, full-range values and small offsets for one lane
	function automatic logic [Q_W-1:0] rand_lane();
		int v;
		case ($urandom_range(0, 9))
			0: v = 524287;
			1: v = -524288;
			2, 3, 4: v = int'($urandom);
			default: v = int'($urandom_range(0, 4096)) - 2048;
		endcase
		return v[Q_W-1:0];
	endfunction

	function automatic logic [DT_W-1:0] rand_life();
		logic [DT_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = DT_W'($urandom);
			default: v = DT_W'($urandom_range(100, 6000));
		endcase
		return v;
	endfunction

	function automatic logic [DT_W-1:0] rand_step();
		logic [DT_W-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = '1;
			2, 3, 4: v = DT_W'($urandom);
			5, 6, 7, 8: v = DT_W'($urandom_range(0, 4000));
			default: v = DT_W'($urandom_range(0, 300));
		endcase
		return v;
	endfunction

	// Write all four registers back to back, then drop the enable
	task automatic write_settings(input logic [VEC_W-1:0] org, input logic [VEC_W-1:0] spr,
			input logic [VEC_W-1:0] bvel, input logic [DT_W-1:0] blife);
		logic [VEC_W-1:0] vals[4];
		cfg_idx_t idx;
		vals[0] = org;
		vals[1] = spr;
		vals[2] = bvel;
		vals[3] = VEC_W'(blife);
		for (int r = 0; r < 4; r++) begin
			idx = cfg_idx_t'(r);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[r];
			@(posedge clk);
			table_sb.set_reg(idx, vals[r]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one command word and hold it until the block takes it
	task automatic issue_command(input logic f, input logic [DT_W-1:0] dt);
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.step_dt <= dt;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		table_sb.note_command(f, dt);
		if (idle_en && !quiet && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Hold the input until every queued word is back, then settle
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Stimulus: directed corners, then random phases
	initial begin
		int sent;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= FUNC_TICK;
		cmd_ch.step_dt <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Moderate settings; the first tick after the second init drives particle 0 to exactly zero
		write_settings(pack_vec(1000, -2000, 300), pack_vec(-513, 77, -1024),
			pack_vec(3000, -700, -1), DT_W'(1024));
		issue_command(FUNC_INIT, '0);
		issue_command(FUNC_TICK, '0);
		issue_command(FUNC_TICK, DT_W'(1));
		issue_command(FUNC_TICK, DT_W'(37));
		issue_command(FUNC_INIT, '1);
		issue_command(FUNC_TICK, DT_W'(1024));
		issue_command(FUNC_TICK, '1);
		drain();

		// Positive extremes: saturate respawn and movement
		write_settings(pack_vec(524287, 524287, 524287), pack_vec(524287, 524287, 524287),
			pack_vec(524287, 524287, 524287), '1);
		issue_command(FUNC_INIT, '0);
		issue_command(FUNC_TICK, DT_W'(100000));
		issue_command(FUNC_TICK, '0);
		issue_command(FUNC_TICK, '1);
		drain();

		// Negative extremes with zero base lifetime
		write_settings(pack_vec(-524288, -524288, -524288), pack_vec(-524288, -524288, -524288),
			pack_vec(-524288, -524288, -524288), '0);
		issue_command(FUNC_INIT, '0);
		issue_command(FUNC_TICK, DT_W'(1));
		issue_command(FUNC_TICK, DT_W'(3000));
		issue_command(FUNC_TICK, DT_W'(50));
		drain();

		// Random phases with fresh settings each time
		sent = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_en = (ph != 3);
			write_settings({rand_lane(), rand_lane(), rand_lane()},
				{rand_lane(), rand_lane(), rand_lane()},
				{rand_lane(), rand_lane(), rand_lane()}, rand_life());
			if ($urandom_range(0, 1) == 0) issue_command(FUNC_INIT, DT_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (sent >= QUIET_FROM) quiet = 1'b1;
				if ($urandom_range(0, 15) == 0) issue_command(FUNC_INIT, DT_W'($urandom));
				else issue_command(FUNC_TICK, rand_step());
				sent++;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
			$display("[particle_lifetime_update] OK");
		end else begin
			$display("[particle_lifetime_update] ERROR");
		end
		$finish;
	end

	// Result side: check each taken word, then pick next ready
	initial begin
		int hold_left;
		bit long_done;
		pos_word_t got;
		hold_left = 0;
		long_done = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.idx = res_ch.particle_index;
				got.x = res_ch.pos_x;
				got.y = res_ch.pos_y;
				got.z = res_ch.pos_z;
				got.respawned = res_ch.respawned;
				got.last = res_ch.last;
				table_sb.check_position(got);
				words_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!long_done && words_seen >= LONG_HOLD_AT) begin
				// Long stall so the block fills and backs up the command side
				long_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (idle_en && !quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 8) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[particle_lifetime_update] ERROR");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
+incdir+design
design/plu_pkg.sv
design/plu_if.sv
design/plu_ram.sv
design/plu_seq.sv
design/plu_upd.sv
design/particle_lifetime_update.sv
design/plu_chk.sv
tb/sv/tb_top.sv
